/* rtl/rarest_piece_selector_core_defines.svh */
`ifndef RAREST_PIECE_SELECTOR_CORE_DEFINES_SVH
`define RAREST_PIECE_SELECTOR_CORE_DEFINES_SVH

// Assertion helpers. Every check is clocked on clk and is off while rst_n is low.

// A condition that must hold in the same cycle.
`define RPS_ASSERT_NOW(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rarest piece selector check failed");

// A trigger that must be followed by a consequence in the next cycle.
`define RPS_ASSERT_NEXT(name, trig, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("rarest piece selector check failed");

`endif

/* rtl/rps_pkg.sv */
`default_nettype none

package rps_pkg;

    localparam int NUM_PIECES_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 8;

    // Fixed field widths of the ports.
    localparam int OP_W     = 3;
    localparam int MASK_W   = 32;
    localparam int PIECE_W  = 5;
    localparam int WANT_W   = 6;
    localparam int CNT_OUT_W = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] PIECES_IN_USE_RST = 6'd32;

    localparam logic [OP_W-1:0] OP_ADD_MASK    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_MASK = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_ONE     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_COUNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_SELECT      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SET = 2'd2;

    typedef struct packed {
        logic inc;   // bump the counter, saturating
        logic dec;   // lower the counter, floored at zero
        logic load;  // latch candidate bit and start the ranking ring
        logic step;  // compare against the passing key and shift the ring
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/rps_cell.sv */
`default_nettype none

module rps_cell #(
    parameter int COUNT_WIDTH = rps_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_WIDTH   = 5,
    parameter int RANK_WIDTH  = 6,
    parameter int CELL_INDEX  = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  rps_pkg::cell_ctrl_t      ctrl,
    input  wire                      cand_in,
    input  wire                      prev_cand,
    input  wire  [COUNT_WIDTH-1:0]   prev_count,
    input  wire  [IDX_WIDTH-1:0]     prev_idx,
    output logic                     pass_cand,
    output logic [COUNT_WIDTH-1:0]   pass_count,
    output logic [IDX_WIDTH-1:0]     pass_idx,
    output logic [COUNT_WIDTH-1:0]   own_count,
    output logic                     own_sel,
    output logic [RANK_WIDTH-1:0]    rank
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_WIDTH-1:0]   MyIdx    = IDX_WIDTH'(CELL_INDEX);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   sel_reg;
    logic                   pass_cand_reg;
    logic [COUNT_WIDTH-1:0] pass_count_reg;
    logic [IDX_WIDTH-1:0]   pass_idx_reg;
    logic [RANK_WIDTH-1:0]  rank_reg;
    logic                   less;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.inc && count_reg != CountMax)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (ctrl.dec && count_reg != '0)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    // The passing key ranks ahead of ours on a lower count, or on a tie with a lower index.
    assign less = (pass_count_reg < count_reg) ||
                  ((pass_count_reg == count_reg) && (pass_idx_reg < MyIdx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sel_reg        <= cand_in;
            pass_cand_reg  <= cand_in;
            pass_count_reg <= count_reg;
            pass_idx_reg   <= MyIdx;
            rank_reg       <= '0;
        end
        else if (ctrl.step)
        begin
            if (sel_reg && pass_cand_reg && less)
            begin
                rank_reg <= rank_reg + RANK_WIDTH'(1);
            end
            pass_cand_reg  <= prev_cand;
            pass_count_reg <= prev_count;
            pass_idx_reg   <= prev_idx;
        end
    end

    assign pass_cand  = pass_cand_reg;
    assign pass_count = pass_count_reg;
    assign pass_idx   = pass_idx_reg;
    assign own_count  = count_reg;
    assign own_sel    = sel_reg;
    assign rank       = rank_reg;

endmodule

`default_nettype wire

/* rtl/rarest_piece_selector_core.sv */
`default_nettype none

// Channel   Handshake                Payload
// in        in_valid / in_ready      opcode, piece_mask, piece_number, how_many
// out       out_valid / out_ready    chosen_piece, count_value, status, last_flag
// cfg       cfg_valid / cfg_ready    cfg_data (pieces_in_use)
//
// Mask, single-piece and read operations update the counters in the accept cycle and
// place the result from the response state; no new request is taken until then.
// A select transaction ranks candidates by sending every key once around the ring of
// cells, then emits one piece per cycle while the output is not stalled.
// Reset clears all counters and sets pieces_in_use to 32.
// A stalled output holds the block in its result phase; cfg is always ready.

`include "rarest_piece_selector_core_defines.svh"

module rarest_piece_selector_core #(
    parameter int NUM_PIECES  = rps_pkg::NUM_PIECES_DEF,
    parameter int COUNT_WIDTH = rps_pkg::COUNT_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [rps_pkg::OP_W-1:0]         opcode,
    input  wire  [rps_pkg::MASK_W-1:0]       piece_mask,
    input  wire  [rps_pkg::PIECE_W-1:0]      piece_number,
    input  wire  [rps_pkg::WANT_W-1:0]       how_many,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rps_pkg::PIECE_W-1:0]      chosen_piece,
    output logic [rps_pkg::CNT_OUT_W-1:0]    count_value,
    output logic [rps_pkg::STATUS_W-1:0]     status,
    output logic                             last_flag,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [rps_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IW  = (NUM_PIECES > 1) ? $clog2(NUM_PIECES) : 1;
    localparam int RW  = $clog2(NUM_PIECES + 1);
    localparam int NW  = (RW > rps_pkg::WANT_W) ? RW : rps_pkg::WANT_W;
    localparam int LimCap = (NUM_PIECES < rps_pkg::MASK_W) ? NUM_PIECES : rps_pkg::MASK_W;
    localparam int LW  = 7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RESP = 2'd1;
    localparam logic [1:0] S_RANK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [rps_pkg::CFG_W-1:0]     piu_reg;
    logic [IW-1:0]                 step_reg, step_next;
    logic [RW-1:0]                 total_reg, total_next;
    logic [RW-1:0]                 n_reg, n_next;
    logic [rps_pkg::WANT_W-1:0]    want_reg, want_next;
    logic [rps_pkg::PIECE_W-1:0]   resp_piece_reg, resp_piece_next;
    logic [rps_pkg::STATUS_W-1:0]  resp_status_reg, resp_status_next;
    logic                          resp_zero_reg, resp_zero_next;

    logic                          out_valid_reg;
    logic [rps_pkg::PIECE_W-1:0]   out_piece_reg;
    logic [rps_pkg::CNT_OUT_W-1:0] out_count_reg;
    logic [rps_pkg::STATUS_W-1:0]  out_status_reg;
    logic                          out_last_reg;

    logic                          in_fire, slot_free, out_load;
    logic [LW-1:0]                 lim;
    logic [rps_pkg::MASK_W-1:0]    vm;
    logic                          mask_bad, pn_ok, sel_bad, start_rank;
    logic                          step_done, emit_last;
    logic [NW-1:0]                 ecount;

    rps_pkg::cell_ctrl_t           ctrl [NUM_PIECES];
    logic                          mask_bit   [NUM_PIECES];
    logic                          pn_in_hit  [NUM_PIECES];
    logic                          pn_hit     [NUM_PIECES];
    logic                          p_cand     [NUM_PIECES];
    logic [COUNT_WIDTH-1:0]        p_count    [NUM_PIECES];
    logic [IW-1:0]                 p_idx      [NUM_PIECES];
    logic [COUNT_WIDTH-1:0]        own_count  [NUM_PIECES];
    logic                          own_sel    [NUM_PIECES];
    logic [RW-1:0]                 rank       [NUM_PIECES];
    logic [NUM_PIECES-1:0]         hit_vec;

    logic [COUNT_WIDTH-1:0]        rd_count, emit_count;
    logic [rps_pkg::PIECE_W-1:0]   emit_piece;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Effective piece limit and the mask of pieces in range.
    always_comb
    begin
        lim = (LW'(piu_reg) > LW'(LimCap)) ? LW'(LimCap) : LW'(piu_reg);
        for (int i = 0; i < rps_pkg::MASK_W; i++)
        begin
            vm[i] = (LW'(i) < lim);
        end
    end

    assign mask_bad   = |(piece_mask & ~vm);
    assign pn_ok      = (LW'(piece_number) < lim);
    assign sel_bad    = (piece_mask == '0) || mask_bad;
    assign start_rank = in_fire && (opcode == rps_pkg::OP_SELECT) && !sel_bad &&
                        (how_many != '0);

    genvar g;
    generate
        for (g = 0; g < NUM_PIECES; g++)
        begin : g_cells
            localparam int Prev = (g == 0) ? NUM_PIECES - 1 : g - 1;

            if (g < rps_pkg::MASK_W)
            begin : g_lo
                assign mask_bit[g]  = piece_mask[g];
                assign pn_in_hit[g] = (piece_number == rps_pkg::PIECE_W'(g));
                assign pn_hit[g]    = (resp_piece_reg == rps_pkg::PIECE_W'(g));
            end
            else
            begin : g_hi
                assign mask_bit[g]  = 1'b0;
                assign pn_in_hit[g] = 1'b0;
                assign pn_hit[g]    = 1'b0;
            end

            assign ctrl[g].inc  = in_fire && (
                                  ((opcode == rps_pkg::OP_ADD_MASK) && !mask_bad &&
                                   mask_bit[g]) ||
                                  ((opcode == rps_pkg::OP_ADD_ONE) && pn_ok && pn_in_hit[g]));
            assign ctrl[g].dec  = in_fire && !mask_bad &&
                                  (opcode == rps_pkg::OP_REMOVE_MASK) && mask_bit[g];
            assign ctrl[g].load = start_rank;
            assign ctrl[g].step = (state_reg == S_RANK);

            rps_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .IDX_WIDTH   (IW),
                .RANK_WIDTH  (RW),
                .CELL_INDEX  (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .cand_in    (mask_bit[g]),
                .prev_cand  (p_cand[Prev]),
                .prev_count (p_count[Prev]),
                .prev_idx   (p_idx[Prev]),
                .pass_cand  (p_cand[g]),
                .pass_count (p_count[g]),
                .pass_idx   (p_idx[g]),
                .own_count  (own_count[g]),
                .own_sel    (own_sel[g]),
                .rank       (rank[g])
            );

            assign hit_vec[g] = own_sel[g] && (rank[g] == n_reg);
        end
    endgenerate

    // Read one counter, and pick the candidate whose rank is next in line.
    always_comb
    begin
        rd_count   = '0;
        emit_count = '0;
        emit_piece = '0;
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            if (pn_hit[i])
            begin
                rd_count = rd_count | own_count[i];
            end
            if (hit_vec[i])
            begin
                emit_count = emit_count | own_count[i];
                emit_piece = emit_piece | rps_pkg::PIECE_W'(i);
            end
        end
    end

    assign ecount    = (NW'(total_reg) < NW'(want_reg)) ? NW'(total_reg) : NW'(want_reg);
    assign emit_last = ((NW'(n_reg) + NW'(1)) == ecount);
    assign step_done = (step_reg == IW'(NUM_PIECES - 1));
    assign out_load  = slot_free && ((state_reg == S_RESP) || (state_reg == S_EMIT));

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        total_next       = total_reg;
        n_next           = n_reg;
        want_next        = want_reg;
        resp_piece_next  = resp_piece_reg;
        resp_status_next = resp_status_reg;
        resp_zero_next   = resp_zero_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    want_next       = how_many;
                    resp_piece_next = piece_number;
                    case (opcode)
                        rps_pkg::OP_ADD_MASK, rps_pkg::OP_REMOVE_MASK:
                        begin
                            state_next       = S_RESP;
                            resp_status_next = mask_bad ? rps_pkg::ST_BAD_IDX : rps_pkg::ST_OK;
                            resp_zero_next   = mask_bad || !pn_ok;
                        end
                        rps_pkg::OP_ADD_ONE, rps_pkg::OP_READ_COUNT:
                        begin
                            state_next       = S_RESP;
                            resp_status_next = pn_ok ? rps_pkg::ST_OK : rps_pkg::ST_BAD_IDX;
                            resp_zero_next   = !pn_ok;
                        end
                        rps_pkg::OP_SELECT:
                        begin
                            if (sel_bad)
                            begin
                                state_next       = S_RESP;
                                resp_piece_next  = '0;
                                resp_status_next = rps_pkg::ST_BAD_SET;
                                resp_zero_next   = 1'b1;
                            end
                            else if (start_rank)
                            begin
                                state_next = S_RANK;
                                step_next  = '0;
                                total_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RANK:
            begin
                // Cell zero sees every key exactly once, so it counts the candidates.
                if (p_cand[0])
                begin
                    total_next = total_reg + RW'(1);
                end
                step_next = step_reg + IW'(1);
                if (step_done)
                begin
                    state_next = S_EMIT;
                    n_next     = '0;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    n_next = n_reg + RW'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            piu_reg       <= rps_pkg::PIECES_IN_USE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                piu_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        total_reg       <= total_next;
        n_reg           <= n_next;
        want_reg        <= want_next;
        resp_piece_reg  <= resp_piece_next;
        resp_status_reg <= resp_status_next;
        resp_zero_reg   <= resp_zero_next;
        if (out_load)
        begin
            if (state_reg == S_RESP)
            begin
                out_piece_reg  <= resp_piece_reg;
                out_count_reg  <= resp_zero_reg ? '0 : rps_pkg::CNT_OUT_W'(rd_count);
                out_status_reg <= resp_status_reg;
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_piece_reg  <= emit_piece;
                out_count_reg  <= rps_pkg::CNT_OUT_W'(emit_count);
                out_status_reg <= rps_pkg::ST_OK;
                out_last_reg   <= emit_last;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_piece = out_piece_reg;
    assign count_value  = out_count_reg;
    assign status       = out_status_reg;
    assign last_flag    = out_last_reg;

    // Ranks of the candidates are distinct, so exactly one cell answers each emit slot.
    `RPS_ASSERT_NOW(a_emit_onehot, (state_reg != S_EMIT) || $onehot(hit_vec))
    // A ring pass that has finished always found at least one candidate.
    `RPS_ASSERT_NEXT(a_rank_total, (state_reg == S_RANK) && step_done,
                     (state_reg == S_EMIT) && (total_reg != '0))
    // The last emitted piece returns the block to idle.
    `RPS_ASSERT_NEXT(a_emit_end, (state_reg == S_EMIT) && slot_free && emit_last,
                     (state_reg == S_IDLE) && out_valid_reg && out_last_reg)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;

    import rps_pkg::*;

    localparam int PIECE_SLOTS   = NUM_PIECES_DEF;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 5000;
    localparam int SHOW_LIMIT    = 10;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MASK_W-1:0]  mask;
        logic [PIECE_W-1:0] piece;
        logic [WANT_W-1:0]  want;
    } piece_req_t;

    typedef struct packed {
        logic [PIECE_W-1:0]   piece;
        logic [CNT_OUT_W-1:0] cnt;
        logic [STATUS_W-1:0]  st;
        logic                 last;
    } piece_pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode = '0;
    logic [MASK_W-1:0]    piece_mask = '0;
    logic [PIECE_W-1:0]   piece_number = '0;
    logic [WANT_W-1:0]    how_many = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIECE_W-1:0]   chosen_piece;
    logic [CNT_OUT_W-1:0] count_value;
    logic [STATUS_W-1:0]  status;
    logic                 last_flag;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow copy of the availability table and the pieces_in_use register.
    logic [COUNT_WIDTH_DEF-1:0] avail_table [PIECE_SLOTS];
    logic [CFG_W-1:0]           pieces_limit_reg = PIECES_IN_USE_RST;

    piece_req_t  piece_requests[$];
    piece_pick_t owed_picks[$];
    piece_req_t  req_in_flight;
    bit          req_holding = 1'b0;
    bit          steady_send = 1'b0;
    bit          steady_take = 1'b0;
    int          mismatches = 0;
    int          stall_cycles = 0;

    rarest_piece_selector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .piece_mask   (piece_mask),
        .piece_number (piece_number),
        .how_many     (how_many),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chosen_piece (chosen_piece),
        .count_value  (count_value),
        .status       (status),
        .last_flag    (last_flag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int piece_limit();
        int lim;
        lim = pieces_limit_reg;
        if (lim > PIECE_SLOTS)
            lim = PIECE_SLOTS;
        return lim;
    endfunction

    function automatic logic [MASK_W-1:0] in_range_mask(input int lim);
        if (lim >= 32)
            return '1;
        return (32'd1 << lim) - 32'd1;
    endfunction

    function automatic void owe_pick(input piece_pick_t p);
        owed_picks = {owed_picks, p};
    endfunction

    // Applies one request to the shadow table and queues the picks it should produce.
    function automatic void rank_and_update(input piece_req_t r);
        int               lim;
        int               best;
        int               n;
        int               total;
        logic [MASK_W-1:0] vm;
        logic [MASK_W-1:0] left;
        piece_pick_t      p;
        lim = piece_limit();
        vm = in_range_mask(lim);
        case (r.op)
            OP_ADD_MASK, OP_REMOVE_MASK:
            begin
                if ((r.mask & ~vm) != '0)
                begin
                    owe_pick('{piece: r.piece, cnt: '0, st: ST_BAD_IDX, last: 1'b1});
                end
                else
                begin
                    for (int i = 0; i < lim; i++)
                    begin
                        if (r.mask[i])
                        begin
                            if (r.op == OP_ADD_MASK)
                            begin
                                if (avail_table[i] != '1)
                                    avail_table[i]++;
                            end
                            else if (avail_table[i] != '0)
                            begin
                                avail_table[i]--;
                            end
                        end
                    end
                    p = '{piece: r.piece, cnt: '0, st: ST_OK, last: 1'b1};
                    if (r.piece < lim)
                        p.cnt = avail_table[r.piece];
                    owe_pick(p);
                end
            end
            OP_ADD_ONE, OP_READ_COUNT:
            begin
                if (r.piece >= lim)
                begin
                    owe_pick('{piece: r.piece, cnt: '0, st: ST_BAD_IDX, last: 1'b1});
                end
                else
                begin
                    if (r.op == OP_ADD_ONE && avail_table[r.piece] != '1)
                        avail_table[r.piece]++;
                    owe_pick('{piece: r.piece, cnt: avail_table[r.piece],
                               st: ST_OK, last: 1'b1});
                end
            end
            OP_SELECT:
            begin
                if (r.mask == '0 || (r.mask & ~vm) != '0)
                begin
                    owe_pick('{piece: '0, cnt: '0, st: ST_BAD_SET, last: 1'b1});
                end
                else
                begin
                    left = r.mask;
                    total = $countones(r.mask);
                    if (r.want < total)
                        total = r.want;
                    for (n = 0; n < total; n++)
                    begin
                        // Lowest count wins; the strict compare keeps the lower index on ties.
                        best = -1;
                        for (int i = 0; i < lim; i++)
                        begin
                            if (left[i] && (best < 0 || avail_table[i] < avail_table[best]))
                                best = i;
                        end
                        left[best] = 1'b0;
                        owe_pick('{piece: PIECE_W'(best), cnt: avail_table[best],
                                   st: ST_OK, last: (n == total - 1)});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Driver: when the channel is free, takes the next request, at random unless steady_send is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rank_and_update(req_in_flight);
                req_holding = 1'b0;
            end
            if (!in_valid || in_ready)
            begin
                if (piece_requests.size() != 0 && (steady_send || $urandom_range(99) >= 24))
                begin
                    req_in_flight = piece_requests.pop_front();
                    req_holding = 1'b1;
                    in_valid <= 1'b1;
                    opcode <= req_in_flight.op;
                    piece_mask <= req_in_flight.mask;
                    piece_number <= req_in_flight.piece;
                    how_many <= req_in_flight.want;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest owed pick.
    always @(posedge clk or negedge rst_n)
    begin
        piece_pick_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_picks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("unexpected result: piece %0d count %0d status %0d last %0d",
                                 chosen_piece, count_value, status, last_flag);
                end
                else
                begin
                    e = owed_picks.pop_front();
                    if (chosen_piece !== e.piece || count_value !== e.cnt ||
                        status !== e.st || last_flag !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     e.piece, e.cnt, e.st, e.last,
                                     chosen_piece, count_value, status, last_flag);
                    end
                end
            end
            out_ready <= steady_take || $urandom_range(99) >= 24;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("rarest_piece_selector_core verification failed");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input logic [MASK_W-1:0] mask,
                            input logic [PIECE_W-1:0] piece, input logic [WANT_W-1:0] want);
        piece_req_t r;
        r = '{op: op, mask: mask, piece: piece, want: want};
        piece_requests = {piece_requests, r};
    endtask

    // Holds the caller back until every request is sent and every owed pick has arrived,
    // then lets the block settle before returning.
    task automatic settle();
        while (piece_requests.size() != 0 || req_holding || owed_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pieces(input logic [CFG_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pieces_limit_reg = v;
    endtask

    task automatic queue_random(input int n);
        piece_req_t       r;
        int               lim;
        int               roll;
        logic [MASK_W-1:0] vm;
        lim = piece_limit();
        vm = in_range_mask(lim);
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
                r.op = OP_ADD_MASK;
            else if (roll < 40)
                r.op = OP_REMOVE_MASK;
            else if (roll < 52)
                r.op = OP_ADD_ONE;
            else if (roll < 64)
                r.op = OP_READ_COUNT;
            else if (roll < 95)
                r.op = OP_SELECT;
            else
                r.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            r.mask = $urandom();
            case ($urandom_range(9))
                0: ;  // raw mask, usually reaching past the pieces in use
                1: r.mask = r.mask & $urandom() & $urandom() & vm;
                2: r.mask = $urandom_range(1) ? '0 : vm;
                default: r.mask = r.mask & vm;
            endcase
            if (lim > 0 && $urandom_range(3) != 0)
                r.piece = PIECE_W'($urandom_range(lim - 1));
            else
                r.piece = PIECE_W'($urandom());
            if ($urandom_range(4) == 0)
                r.want = WANT_W'($urandom());
            else
                r.want = WANT_W'($urandom_range(6));
            piece_requests = {piece_requests, r};
        end
    endtask

    initial
    begin
        for (int i = 0; i < PIECE_SLOTS; i++)
            avail_table[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of pieces_in_use: floor at zero, all-ones masks, ties and spare codes.
        push_req(OP_READ_COUNT, '0, 5'd0, '0);
        push_req(OP_REMOVE_MASK, '1, 5'd31, '0);
        push_req(OP_ADD_MASK, '1, 5'd31, '0);
        push_req(OP_ADD_MASK, 32'h0000_0005, 5'd2, '0);
        push_req(OP_ADD_ONE, '0, 5'd31, '0);
        push_req(OP_ADD_ONE, '0, 5'd0, '0);
        push_req(OP_READ_COUNT, '0, 5'd31, '0);
        push_req(OP_SELECT, '1, 5'd0, 6'd32);
        push_req(OP_SELECT, 32'h8000_0001, 5'd7, '1);
        push_req(OP_SELECT, '0, 5'd0, 6'd4);
        push_req(OP_SELECT, 32'h0000_00F0, 5'd0, '0);
        push_req(OP_SPARE_LO, '1, '1, '1);
        push_req(OP_SPARE_HI, '1, '1, '1);
        push_req(OP_REMOVE_MASK, 32'h0000_0005, 5'd0, '0);
        push_req(OP_SELECT, 32'hA5A5_5A5A, 5'd0, 6'd3);

        // Eight pieces in use: out-of-range masks, echoed index, single pieces and sets.
        write_pieces(6'd8);
        push_req(OP_ADD_MASK, 32'h0000_0100, 5'd3, '0);
        push_req(OP_ADD_MASK, 32'h0000_00FF, 5'd20, '0);
        push_req(OP_ADD_ONE, '0, 5'd8, '0);
        push_req(OP_READ_COUNT, '0, 5'd31, '0);
        push_req(OP_SELECT, 32'h0000_01FF, 5'd0, 6'd2);
        push_req(OP_SELECT, 32'h0000_00FF, 5'd0, 6'd4);

        // No pieces in use: every index is out of range.
        write_pieces(6'd0);
        push_req(OP_ADD_MASK, '0, 5'd0, '0);
        push_req(OP_REMOVE_MASK, 32'h0000_0001, 5'd1, '0);
        push_req(OP_READ_COUNT, '0, 5'd0, '0);
        push_req(OP_SELECT, 32'h0000_0001, 5'd0, 6'd1);

        write_pieces(6'd63);
        push_req(OP_READ_COUNT, '0, 5'd31, '0);

        // A stretch with both sides always ready.
        write_pieces(6'd32);
        steady_send = 1'b1;
        steady_take = 1'b1;
        queue_random(60);
        settle();
        steady_send = 1'b0;
        steady_take = 1'b0;

        write_pieces(6'd1);
        queue_random(25);
        write_pieces(6'd5);
        queue_random(40);
        write_pieces(6'd20);
        queue_random(45);

        // The full table once more with a final random mix.
        write_pieces(6'd32);
        queue_random(35);

        settle();
        if (mismatches == 0)
            $display("rarest_piece_selector_core verification clean");
        else
            $display("rarest_piece_selector_core verification failed");
        $finish;
    end

endmodule
